>>> hw/rtl/chacha_pkg.sv
// shared types, constants and helper functions for the chacha20 stream cipher
package chacha_pkg;

  localparam int unsigned DOUBLE_ROUNDS = 10;
  localparam int unsigned DR_W          = $clog2(DOUBLE_ROUNDS);

  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;

  localparam int unsigned ROT_A1 = 16;
  localparam int unsigned ROT_B1 = 12;
  localparam int unsigned ROT_A2 = 8;
  localparam int unsigned ROT_B2 = 7;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_0_7     = 3'd0,
    CFG_KEY_8_15    = 3'd1,
    CFG_KEY_16_23   = 3'd2,
    CFG_KEY_24_31   = 3'd3,
    CFG_NONCE_0_7   = 3'd4,
    CFG_NONCE_8_11  = 3'd5,
    CFG_START_CTR   = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GEN,
    ST_XOR
  } top_state_e;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_ROUND,
    CS_FINAL
  } core_state_e;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
  } in_item_t;

  typedef struct packed {
    logic [63:0] cipher_word;
    logic [3:0]  out_valid_bytes;
    logic        out_last;
  } out_item_t;

  typedef struct packed {
    logic [3:0][63:0] key;
    logic [63:0]      nonce_lo;
    logic [31:0]      nonce_hi;
    logic [31:0]      start_counter;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [31:0] ctr;
  } core_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_rsp_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_quad_t;

  typedef logic [15:0][31:0] st_t;

  // initial block state from key, nonce and block counter
  function automatic st_t chacha_init(cfg_t c, logic [31:0] ctr);
    st_t s;
    s[0] = SIGMA_0;
    s[1] = SIGMA_1;
    s[2] = SIGMA_2;
    s[3] = SIGMA_3;
    for (int i = 0; i < 4; i++) begin
      s[4 + 2*i] = c.key[i][31:0];
      s[5 + 2*i] = c.key[i][63:32];
    end
    s[12] = ctr;
    s[13] = c.nonce_lo[31:0];
    s[14] = c.nonce_lo[63:32];
    s[15] = c.nonce_hi;
    return s;
  endfunction

  // byte count 1..7 keeps the low bytes, anything else keeps all eight
  function automatic logic [63:0] byte_mask(logic [3:0] vb);
    logic [63:0] m;
    for (int i = 0; i < 8; i++) begin
      m[i*8 +: 8] = ((4'(i) < vb) || (vb == 4'd0) || (vb > 4'd8)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/chacha_cfg.sv
// configuration register file for key, nonce and start counter
module chacha_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [chacha_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [63:0]                       cfg_wdata_i,
  output chacha_pkg::cfg_t                  cfg_o
);

  chacha_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        chacha_pkg::CFG_KEY_0_7:    cfg_d.key[0]        = cfg_wdata_i;
        chacha_pkg::CFG_KEY_8_15:   cfg_d.key[1]        = cfg_wdata_i;
        chacha_pkg::CFG_KEY_16_23:  cfg_d.key[2]        = cfg_wdata_i;
        chacha_pkg::CFG_KEY_24_31:  cfg_d.key[3]        = cfg_wdata_i;
        chacha_pkg::CFG_NONCE_0_7:  cfg_d.nonce_lo      = cfg_wdata_i;
        chacha_pkg::CFG_NONCE_8_11: cfg_d.nonce_hi      = cfg_wdata_i[31:0];
        chacha_pkg::CFG_START_CTR:  cfg_d.start_counter = cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{key: '0, nonce_lo: '0, nonce_hi: '0, start_counter: 32'd1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/chacha_qr_half.sv
// half of a quarter round: two add, xor, rotate steps
module chacha_qr_half (
  input  chacha_pkg::qr_quad_t q_i,
  input  logic                 second_i,
  output chacha_pkg::qr_quad_t q_o
);

  logic [31:0] a_n, b_x, c_n, d_x, d_n, b_n;

  always_comb begin
    a_n = q_i.a + q_i.b;
    d_x = q_i.d ^ a_n;
    d_n = second_i ? {d_x[31-chacha_pkg::ROT_A2:0], d_x[31:32-chacha_pkg::ROT_A2]}
                   : {d_x[31-chacha_pkg::ROT_A1:0], d_x[31:32-chacha_pkg::ROT_A1]};
    c_n = q_i.c + d_n;
    b_x = q_i.b ^ c_n;
    b_n = second_i ? {b_x[31-chacha_pkg::ROT_B2:0], b_x[31:32-chacha_pkg::ROT_B2]}
                   : {b_x[31-chacha_pkg::ROT_B1:0], b_x[31:32-chacha_pkg::ROT_B1]};
    q_o = '{a: a_n, b: b_n, c: c_n, d: d_n};
  end

endmodule

>>> hw/rtl/chacha_core.sv
// keystream block generator: sequencer around one shared half quarter round unit
module chacha_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  chacha_pkg::cfg_t      cfg_i,
  input  chacha_pkg::core_req_t req_i,
  output chacha_pkg::core_rsp_t rsp_o,
  input  logic [2:0]            rd_idx_i,
  output logic [63:0]           ks_word_o
);

  chacha_pkg::core_state_e state_q, state_d;

  chacha_pkg::st_t         st_q, st_d, upd, rot, init;
  logic [31:0]             ctr_q;
  logic                    half_q;
  logic [2:0]              qr_q;
  logic [chacha_pkg::DR_W-1:0] dr_q;
  logic [7:0][63:0]        ks_q;
  logic [1:0]              amt [4];
  logic [1:0]              col;
  logic                    last_step;

  chacha_pkg::qr_quad_t    qin, qout;

  // the unit always works on column zero of the row-major state
  assign qin = '{a: st_q[0], b: st_q[4], c: st_q[8], d: st_q[12]};

  chacha_qr_half u_qr (
    .q_i      (qin),
    .second_i (half_q),
    .q_o      (qout)
  );

  assign init      = chacha_pkg::chacha_init(cfg_i, ctr_q);
  assign last_step = half_q && (qr_q == 3'd7) &&
                     (dr_q == chacha_pkg::DR_W'(chacha_pkg::DOUBLE_ROUNDS - 1));

  // row rotations bring the next column or diagonal into column zero
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      if (!half_q)           amt[r] = 2'd0;
      else if (qr_q == 3'd3) amt[r] = 2'(r + 1);
      else if (qr_q == 3'd7) amt[r] = 2'(5 - r);
      else                   amt[r] = 2'd1;
    end
    upd     = st_q;
    upd[0]  = qout.a;
    upd[4]  = qout.b;
    upd[8]  = qout.c;
    upd[12] = qout.d;
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        col = 2'(j) + amt[r];
        rot[{2'(r), 2'(j)}] = upd[{2'(r), col}];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      chacha_pkg::CS_IDLE:  if (req_i.start) state_d = chacha_pkg::CS_ROUND;
      chacha_pkg::CS_ROUND: if (last_step)   state_d = chacha_pkg::CS_FINAL;
      chacha_pkg::CS_FINAL: state_d = chacha_pkg::CS_IDLE;
      default:              state_d = chacha_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.busy = (state_q != chacha_pkg::CS_IDLE);
    rsp_o.done = (state_q == chacha_pkg::CS_FINAL);
  end

  always_comb begin
    st_d = st_q;
    if (state_q == chacha_pkg::CS_IDLE && req_i.start) begin
      st_d = chacha_pkg::chacha_init(cfg_i, req_i.ctr);
    end else if (state_q == chacha_pkg::CS_ROUND) begin
      st_d = rot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= chacha_pkg::CS_IDLE;
      half_q  <= 1'b0;
      qr_q    <= '0;
      dr_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == chacha_pkg::CS_IDLE) begin
        half_q <= 1'b0;
        qr_q   <= '0;
        dr_q   <= '0;
      end else if (state_q == chacha_pkg::CS_ROUND) begin
        half_q <= ~half_q;
        if (half_q) begin
          qr_q <= qr_q + 3'd1;
          if (qr_q == 3'd7) dr_q <= dr_q + chacha_pkg::DR_W'(1);
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    if (state_q == chacha_pkg::CS_IDLE && req_i.start) ctr_q <= req_i.ctr;
    if (state_q == chacha_pkg::CS_FINAL) begin
      // feed-forward add of the initial state
      for (int k = 0; k < 8; k++) begin
        ks_q[k] <= {st_q[2*k+1] + init[2*k+1], st_q[2*k] + init[2*k]};
      end
    end
  end

  assign ks_word_o = ks_q[rd_idx_i];

endmodule

>>> hw/rtl/chacha20_stream_cipher.sv
// top level of the chacha20 stream cipher: word sequencing, xor and output register
//
// usage:
//   in channel (in_valid_i / in_ready_o / in_data_i) carries 64-bit message words,
//   first byte in bits 7:0, with a last flag and a byte count for the final word
//   out channel (out_valid_o / out_ready_i / out_data_o) returns one word per input
//   word, data xor keystream, bytes beyond the count forced to zero
//   config port (cfg_we_i / cfg_idx_i / cfg_wdata_i) writes key, nonce and the
//   start counter in one cycle; write only while no word is in flight
// timing:
//   the first word of each 64-byte block waits for a keystream block: one load
//   cycle, 160 cycles of the shared half quarter round unit (10 double rounds of
//   16 half steps each), one feed-forward cycle and one xor cycle, about 163 cycles
//   the other seven words of a block take 2 cycles each (transfer, then xor)
//   so a full block of eight words takes about 177 cycles
// reset clears the message state; the next word starts a new message and loads
// the counter from start_counter (1 after reset)
// a stalled receiver holds the result in the output register; one more word can
// be taken and processed, then in_ready_o stays low until the register drains
module chacha20_stream_cipher (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [chacha_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]                      cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  chacha_pkg::in_item_t             in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output chacha_pkg::out_item_t            out_data_o
);

  chacha_pkg::top_state_e state_q, state_d;

  chacha_pkg::cfg_t       cfg;
  chacha_pkg::core_req_t  core_req;
  chacha_pkg::core_rsp_t  core_rsp;
  logic [63:0]            ks_word;

  chacha_pkg::in_item_t   item_q;
  chacha_pkg::out_item_t  out_q, out_d;
  logic                   out_valid_q;
  logic [2:0]             pos_q, pos_eff;
  logic                   in_msg_q;
  logic [31:0]            block_count_q;
  logic                   in_fire, out_free, out_load, need_block;
  logic [3:0]             vb_eff;

  chacha_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  chacha_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .req_i     (core_req),
    .rsp_o     (core_rsp),
    .rd_idx_i  (pos_q),
    .ks_word_o (ks_word)
  );

  // a new message always starts at word zero of a fresh block
  assign pos_eff    = in_msg_q ? pos_q : 3'd0;
  assign need_block = (pos_eff == 3'd0);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      chacha_pkg::ST_IDLE: if (in_fire) state_d = need_block ? chacha_pkg::ST_GEN
                                                            : chacha_pkg::ST_XOR;
      chacha_pkg::ST_GEN:  if (core_rsp.done) state_d = chacha_pkg::ST_XOR;
      chacha_pkg::ST_XOR:  if (out_free) state_d = chacha_pkg::ST_IDLE;
      default:             state_d = chacha_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = (state_q == chacha_pkg::ST_IDLE);
    out_load       = (state_q == chacha_pkg::ST_XOR) && out_free;
    core_req.start = in_fire && need_block;
    // counter reloads from config at a message start
    core_req.ctr   = in_msg_q ? block_count_q : cfg.start_counter;
  end

  // result word: a byte count only counts on the last word, bad counts mean eight
  always_comb begin
    vb_eff = 4'd8;
    if (item_q.last_word && item_q.valid_bytes != 4'd0 && item_q.valid_bytes <= 4'd8) begin
      vb_eff = item_q.valid_bytes;
    end
    out_d.cipher_word     = (item_q.data_word ^ ks_word) & chacha_pkg::byte_mask(vb_eff);
    out_d.out_valid_bytes = vb_eff;
    out_d.out_last        = item_q.last_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= chacha_pkg::ST_IDLE;
      out_valid_q   <= 1'b0;
      pos_q         <= 3'd0;
      in_msg_q      <= 1'b0;
      block_count_q <= 32'd0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        pos_q <= pos_eff;
        if (need_block) block_count_q <= core_req.ctr + 32'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        if (item_q.last_word) begin
          pos_q    <= 3'd0;
          in_msg_q <= 1'b0;
        end else begin
          pos_q    <= pos_q + 3'd1;
          in_msg_q <= 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire)  item_q <= in_data_i;
    if (out_load) out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/chacha_checker.sv
// port-level assertions for the chacha20 stream cipher, bound to the top level
module chacha_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input chacha_pkg::out_item_t out_data_o
);

  logic [1:0] pending_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;

  // words taken but not yet returned
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
    end else if (in_xfer && !out_xfer) begin
      pending_q <= pending_q + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pending_q != 2'd0)
    else $error("result without a matching input transfer");

  a_full_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.out_last |-> out_data_o.out_valid_bytes == 4'd8)
    else $error("short byte count on a word that is not last");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.out_valid_bytes >= 4'd1 && out_data_o.out_valid_bytes <= 4'd8)
    else $error("byte count out of range");

  a_tail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.cipher_word & ~chacha_pkg::byte_mask(out_data_o.out_valid_bytes)) == 64'd0)
    else $error("bytes beyond the count are not zero");

endmodule

bind chacha20_stream_cipher chacha_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
